FILE: design/aesp_pkg.sv
// Shared types and constants for the terminal escape-sequence parser.
package aesp_pkg;

  typedef enum logic [2:0] {
    MODE_GROUND  = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_CSI     = 3'd2,
    MODE_OSC     = 3'd3,
    MODE_OSC_ESC = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    PAT_EMPTY        = 3'd0,
    PAT_ZERO         = 3'd1,
    PAT_TWO          = 3'd2,
    PAT_ONE          = 3'd3,
    PAT_ONE_SEMI     = 3'd4,
    PAT_ONE_SEMI_ONE = 3'd5,
    PAT_OTHER        = 3'd6
  } pat_t;

  typedef enum logic [2:0] {
    ACT_PRINT     = 3'd0,
    ACT_NEWLINE   = 3'd1,
    ACT_TAB       = 3'd2,
    ACT_RETURN    = 3'd3,
    ACT_BACKSPACE = 3'd4,
    ACT_ERASE_EOL = 3'd5,
    ACT_ERASE_LN  = 3'd6,
    ACT_HOME      = 3'd7
  } act_t;

  typedef struct packed {
    act_t       action;
    logic [7:0] char_out;
    logic [4:0] fg_color;
    logic       bold;
  } cmd_t;

  localparam logic [7:0] BYTE_BEL      = 8'h07;
  localparam logic [7:0] BYTE_BS       = 8'h08;
  localparam logic [7:0] BYTE_TAB      = 8'h09;
  localparam logic [7:0] BYTE_LF       = 8'h0A;
  localparam logic [7:0] BYTE_CR       = 8'h0D;
  localparam logic [7:0] BYTE_ESC      = 8'h1B;
  localparam logic [7:0] BYTE_PRINT_LO = 8'h20;
  localparam logic [7:0] BYTE_DIGIT_0  = 8'h30;
  localparam logic [7:0] BYTE_DIGIT_1  = 8'h31;
  localparam logic [7:0] BYTE_DIGIT_2  = 8'h32;
  localparam logic [7:0] BYTE_DIGIT_9  = 8'h39;
  localparam logic [7:0] BYTE_SEMI     = 8'h3B;
  localparam logic [7:0] BYTE_FINAL_LO = 8'h40;
  localparam logic [7:0] BYTE_H        = 8'h48;
  localparam logic [7:0] BYTE_K        = 8'h4B;
  localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
  localparam logic [7:0] BYTE_BSLASH   = 8'h5C;
  localparam logic [7:0] BYTE_RBRACKET = 8'h5D;
  localparam logic [7:0] BYTE_ESC2_HI  = 8'h5F;
  localparam logic [7:0] BYTE_M        = 8'h6D;
  localparam logic [7:0] BYTE_FINAL_HI = 8'h7E;

  localparam logic [4:0]  FG_DEFAULT = 5'd16;
  localparam logic [31:0] PARAM_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] SGR_RESET  = 32'd0;
  localparam logic [31:0] SGR_BOLD   = 32'd1;
  localparam logic [31:0] SGR_FG_LO  = 32'd30;
  localparam logic [31:0] SGR_FG_HI  = 32'd37;
  localparam logic [31:0] SGR_BFG_LO = 32'd90;
  localparam logic [31:0] SGR_BFG_HI = 32'd97;

endpackage

FILE: design/ansi_escape_stream_parser_top.sv
// A byte word waits in the input register until the core takes it; its command is then
// loaded into the result register. Throughput: one byte word per cycle while the result
// slot is free; the input and result registers keep both sides moving. Bytes that yield
// no command (escape, CSI and OSC bytes, dropped controls) are taken while it is full.
// Reset: synchronous; clears both register stages, returns to ground mode and
// restores the default foreground color with bold off.
module ansi_escape_stream_parser_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] byte_in,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output logic [2:0] action,
  output logic [7:0] char_out,
  output logic [4:0] fg_color,
  output logic       bold
);

  logic           item_valid;
  logic [7:0]     item_byte;
  logic           take;
  logic           emit;
  logic           slot_free;
  aesp_pkg::cmd_t cmd_core;
  aesp_pkg::cmd_t cmd_reg;

  aesp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_in    (byte_in),
    .take       (take),
    .item_valid (item_valid),
    .item_byte  (item_byte)
  );

  aesp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .slot_free  (slot_free),
    .take       (take),
    .emit       (emit),
    .cmd        (cmd_core)
  );

  aesp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && emit),
    .cmd_in    (cmd_core),
    .slot_free (slot_free),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_out   (cmd_reg)
  );

  assign action   = cmd_reg.action;
  assign char_out = cmd_reg.char_out;
  assign fg_color = cmd_reg.fg_color;
  assign bold     = cmd_reg.bold;

endmodule

FILE: design/aesp_in_stage.sv
// Input register holding one byte word ahead of the parser.
module aesp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] byte_in,
  input  logic       take,
  output logic       item_valid,
  output logic [7:0] item_byte
);

  logic       hold_valid;
  logic [7:0] hold_byte;

  assign byte_ready = !hold_valid || take;
  assign item_valid = hold_valid;
  assign item_byte  = hold_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      hold_byte <= byte_in;
    end
  end

endmodule

FILE: design/aesp_core.sv
// Escape grammar state, SGR attribute tracking and command decode.
module aesp_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  logic [7:0]      item_byte,
  input  logic            slot_free,
  output logic            take,
  output logic            emit,
  output aesp_pkg::cmd_t  cmd
);

  aesp_pkg::mode_t mode, mode_next;
  aesp_pkg::pat_t  pat, pat_next;
  logic [31:0] accum, accum_next;
  logic        invalid, invalid_next;
  logic [4:0]  shadow_fg, shadow_fg_next;
  logic        shadow_bold, shadow_bold_next;
  logic [4:0]  active_fg, active_fg_next;
  logic        active_bold, active_bold_next;

  logic        is_final;
  logic        is_digit;
  logic        is_esc2;
  logic [3:0]  digit;
  logic [35:0] acc_sum;
  logic        acc_ovf;
  logic [31:0] pval;
  logic [31:0] fg_off;
  logic [31:0] bfg_off;
  logic [4:0]  ap_fg;
  logic        ap_bold;
  logic        g_emit;
  aesp_pkg::act_t g_action;
  logic [7:0]  g_char;

  assign is_final = (item_byte >= aesp_pkg::BYTE_FINAL_LO) &&
                    (item_byte <= aesp_pkg::BYTE_FINAL_HI);
  assign is_digit = (item_byte >= aesp_pkg::BYTE_DIGIT_0) &&
                    (item_byte <= aesp_pkg::BYTE_DIGIT_9);
  assign is_esc2  = (item_byte >= aesp_pkg::BYTE_FINAL_LO) &&
                    (item_byte <= aesp_pkg::BYTE_ESC2_HI);
  assign digit    = 4'(item_byte - aesp_pkg::BYTE_DIGIT_0);
  assign acc_sum  = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0} + {32'd0, digit};
  assign acc_ovf  = acc_sum > {4'd0, aesp_pkg::PARAM_MAX};

  assign pval    = invalid ? 32'd0 : accum;
  assign fg_off  = pval - aesp_pkg::SGR_FG_LO;
  assign bfg_off = pval - aesp_pkg::SGR_BFG_LO;

  always_comb begin
    ap_fg   = shadow_fg;
    ap_bold = shadow_bold;
    if (pval == aesp_pkg::SGR_RESET) begin
      ap_fg   = aesp_pkg::FG_DEFAULT;
      ap_bold = 1'b0;
    end else if (pval == aesp_pkg::SGR_BOLD) begin
      ap_bold = 1'b1;
    end else if (pval >= aesp_pkg::SGR_FG_LO && pval <= aesp_pkg::SGR_FG_HI) begin
      ap_fg = {2'b00, fg_off[2:0]};
    end else if (pval >= aesp_pkg::SGR_BFG_LO && pval <= aesp_pkg::SGR_BFG_HI) begin
      ap_fg = {2'b01, bfg_off[2:0]};
    end
  end

  always_comb begin
    g_emit   = 1'b1;
    g_action = aesp_pkg::ACT_PRINT;
    g_char   = 8'd0;
    if (item_byte == aesp_pkg::BYTE_CR) begin
      g_action = aesp_pkg::ACT_RETURN;
    end else if (item_byte == aesp_pkg::BYTE_BS) begin
      g_action = aesp_pkg::ACT_BACKSPACE;
    end else if (item_byte == aesp_pkg::BYTE_LF) begin
      g_action = aesp_pkg::ACT_NEWLINE;
    end else if (item_byte == aesp_pkg::BYTE_TAB) begin
      g_action = aesp_pkg::ACT_TAB;
    end else if (item_byte < aesp_pkg::BYTE_PRINT_LO) begin
      g_emit = 1'b0;
    end else begin
      g_char = item_byte;
    end
  end

  // next parse mode
  always_comb begin
    mode_next = mode;
    unique case (mode)
      aesp_pkg::MODE_ESC: begin
        if (item_byte == aesp_pkg::BYTE_LBRACKET) begin
          mode_next = aesp_pkg::MODE_CSI;
        end else if (item_byte == aesp_pkg::BYTE_RBRACKET) begin
          mode_next = aesp_pkg::MODE_OSC;
        end else if (!is_esc2 && item_byte == aesp_pkg::BYTE_ESC) begin
          mode_next = aesp_pkg::MODE_ESC;
        end else begin
          mode_next = aesp_pkg::MODE_GROUND;
        end
      end
      aesp_pkg::MODE_CSI: begin
        if (is_final) begin
          mode_next = aesp_pkg::MODE_GROUND;
        end
      end
      aesp_pkg::MODE_OSC: begin
        if (item_byte == aesp_pkg::BYTE_BEL) begin
          mode_next = aesp_pkg::MODE_GROUND;
        end else if (item_byte == aesp_pkg::BYTE_ESC) begin
          mode_next = aesp_pkg::MODE_OSC_ESC;
        end
      end
      aesp_pkg::MODE_OSC_ESC: begin
        if (item_byte == aesp_pkg::BYTE_BSLASH || item_byte == aesp_pkg::BYTE_BEL) begin
          mode_next = aesp_pkg::MODE_GROUND;
        end else if (item_byte != aesp_pkg::BYTE_ESC) begin
          mode_next = aesp_pkg::MODE_OSC;
        end
      end
      default: begin
        mode_next = (item_byte == aesp_pkg::BYTE_ESC) ? aesp_pkg::MODE_ESC
                                                      : aesp_pkg::MODE_GROUND;
      end
    endcase
  end

  // datapath and command outputs
  always_comb begin
    accum_next       = accum;
    invalid_next     = invalid;
    pat_next         = pat;
    shadow_fg_next   = shadow_fg;
    shadow_bold_next = shadow_bold;
    active_fg_next   = active_fg;
    active_bold_next = active_bold;
    emit             = 1'b0;
    cmd.action       = aesp_pkg::ACT_PRINT;
    cmd.char_out     = 8'd0;
    cmd.fg_color     = active_fg;
    cmd.bold         = active_bold;
    unique case (mode)
      aesp_pkg::MODE_ESC: begin
        if (item_byte == aesp_pkg::BYTE_LBRACKET) begin
          accum_next       = 32'd0;
          invalid_next     = 1'b0;
          pat_next         = aesp_pkg::PAT_EMPTY;
          shadow_fg_next   = active_fg;
          shadow_bold_next = active_bold;
        end else if (item_byte != aesp_pkg::BYTE_RBRACKET && !is_esc2) begin
          emit         = g_emit;
          cmd.action   = g_action;
          cmd.char_out = g_char;
        end
      end
      aesp_pkg::MODE_CSI: begin
        if (is_final) begin
          if (item_byte == aesp_pkg::BYTE_M) begin
            shadow_fg_next   = ap_fg;
            shadow_bold_next = ap_bold;
            active_fg_next   = ap_fg;
            active_bold_next = ap_bold;
            accum_next       = 32'd0;
            invalid_next     = 1'b0;
          end else if (item_byte == aesp_pkg::BYTE_K &&
                       (pat == aesp_pkg::PAT_EMPTY || pat == aesp_pkg::PAT_ZERO)) begin
            emit       = 1'b1;
            cmd.action = aesp_pkg::ACT_ERASE_EOL;
          end else if (item_byte == aesp_pkg::BYTE_K && pat == aesp_pkg::PAT_TWO) begin
            emit       = 1'b1;
            cmd.action = aesp_pkg::ACT_ERASE_LN;
          end else if (item_byte == aesp_pkg::BYTE_H &&
                       (pat == aesp_pkg::PAT_EMPTY ||
                        pat == aesp_pkg::PAT_ONE_SEMI_ONE)) begin
            emit       = 1'b1;
            cmd.action = aesp_pkg::ACT_HOME;
          end
        end else if (item_byte == aesp_pkg::BYTE_SEMI) begin
          shadow_fg_next   = ap_fg;
          shadow_bold_next = ap_bold;
          accum_next       = 32'd0;
          invalid_next     = 1'b0;
          pat_next = (pat == aesp_pkg::PAT_ONE) ? aesp_pkg::PAT_ONE_SEMI
                                                : aesp_pkg::PAT_OTHER;
        end else if (is_digit) begin
          if (!invalid) begin
            if (acc_ovf) begin
              invalid_next = 1'b1;
              accum_next   = 32'd0;
            end else begin
              accum_next = acc_sum[31:0];
            end
          end
          if (pat == aesp_pkg::PAT_EMPTY && item_byte == aesp_pkg::BYTE_DIGIT_0) begin
            pat_next = aesp_pkg::PAT_ZERO;
          end else if (pat == aesp_pkg::PAT_EMPTY &&
                       item_byte == aesp_pkg::BYTE_DIGIT_2) begin
            pat_next = aesp_pkg::PAT_TWO;
          end else if (pat == aesp_pkg::PAT_EMPTY &&
                       item_byte == aesp_pkg::BYTE_DIGIT_1) begin
            pat_next = aesp_pkg::PAT_ONE;
          end else if (pat == aesp_pkg::PAT_ONE_SEMI &&
                       item_byte == aesp_pkg::BYTE_DIGIT_1) begin
            pat_next = aesp_pkg::PAT_ONE_SEMI_ONE;
          end else begin
            pat_next = aesp_pkg::PAT_OTHER;
          end
        end else begin
          invalid_next = 1'b1;
          accum_next   = 32'd0;
          pat_next     = aesp_pkg::PAT_OTHER;
        end
      end
      aesp_pkg::MODE_OSC, aesp_pkg::MODE_OSC_ESC: begin
        emit = 1'b0;
      end
      default: begin
        emit         = g_emit;
        cmd.action   = g_action;
        cmd.char_out = g_char;
      end
    endcase
  end

  assign take = item_valid && (!emit || slot_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= aesp_pkg::MODE_GROUND;
      pat         <= aesp_pkg::PAT_EMPTY;
      accum       <= 32'd0;
      invalid     <= 1'b0;
      shadow_fg   <= aesp_pkg::FG_DEFAULT;
      shadow_bold <= 1'b0;
      active_fg   <= aesp_pkg::FG_DEFAULT;
      active_bold <= 1'b0;
    end else if (take) begin
      mode        <= mode_next;
      pat         <= pat_next;
      accum       <= accum_next;
      invalid     <= invalid_next;
      shadow_fg   <= shadow_fg_next;
      shadow_bold <= shadow_bold_next;
      active_fg   <= active_fg_next;
      active_bold <= active_bold_next;
    end
  end

  a_no_take_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (emit && !slot_free) |-> !take)
    else $error("word taken while result slot is full");

  a_osc_silent: assert property (@(posedge clk) disable iff (rst)
    (mode == aesp_pkg::MODE_OSC || mode == aesp_pkg::MODE_OSC_ESC) |-> !emit)
    else $error("command produced inside OSC body");

  a_csi_entry: assert property (@(posedge clk) disable iff (rst)
    (take && mode == aesp_pkg::MODE_ESC && item_byte == aesp_pkg::BYTE_LBRACKET)
    |=> (mode == aesp_pkg::MODE_CSI && accum == 32'd0 && pat == aesp_pkg::PAT_EMPTY))
    else $error("CSI entry did not clear parameter state");

  a_accum_bound: assert property (@(posedge clk) disable iff (rst)
    !accum[31])
    else $error("parameter accumulator exceeded its limit");

endmodule

FILE: design/aesp_out_stage.sv
// Result register holding one command word for the output channel.
module aesp_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  aesp_pkg::cmd_t  cmd_in,
  output logic            slot_free,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output aesp_pkg::cmd_t  cmd_out
);

  logic           hold_valid;
  aesp_pkg::cmd_t hold_cmd;

  assign slot_free = !hold_valid || cmd_ready;
  assign cmd_valid = hold_valid;
  assign cmd_out   = hold_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (load) begin
      hold_valid <= 1'b1;
    end else if (cmd_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_cmd <= cmd_in;
    end
  end

endmodule

FILE: tb/ansi_escape_stream_parser_top_test.sv
// Self-checking testbench: random and directed byte streams through the escape parser.
module ansi_escape_stream_parser_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 1950;
  localparam int IDLE_LIMIT   = 2000;
  localparam int MAX_PRINTS   = 100;

  class term_cmd_model;
    aesp_pkg::mode_t mode;
    logic [31:0]     accum;
    bit              bad_param;
    aesp_pkg::pat_t  pat;
    logic [4:0]      next_fg;
    bit              next_bold;
    logic [4:0]      cur_fg;
    bit              cur_bold;
    aesp_pkg::cmd_t  pending_cmds[$];
    int              mismatches;
    int              bytes_seen;
    int              cmds_seen;

    function new();
      mode       = aesp_pkg::MODE_GROUND;
      accum      = '0;
      bad_param  = 1'b0;
      pat        = aesp_pkg::PAT_EMPTY;
      next_fg    = aesp_pkg::FG_DEFAULT;
      next_bold  = 1'b0;
      cur_fg     = aesp_pkg::FG_DEFAULT;
      cur_bold   = 1'b0;
      mismatches = 0;
      bytes_seen = 0;
      cmds_seen  = 0;
    endfunction

    task report_mismatch(string what, int got_v, int want_v);
      if (mismatches < MAX_PRINTS) begin
        $display("mismatch at command %0d: %s got %0d want %0d",
                 cmds_seen, what, got_v, want_v);
      end
      mismatches++;
    endtask

    function void emit(aesp_pkg::act_t a, logic [7:0] ch);
      aesp_pkg::cmd_t c;
      c.action   = a;
      c.char_out = ch;
      c.fg_color = cur_fg;
      c.bold     = cur_bold;
      pending_cmds.push_back(c);
    endfunction

    function void ground_byte(logic [7:0] b);
      if (b == aesp_pkg::BYTE_ESC) mode = aesp_pkg::MODE_ESC;
      else if (b == aesp_pkg::BYTE_CR) emit(aesp_pkg::ACT_RETURN, 8'h00);
      else if (b == aesp_pkg::BYTE_BS) emit(aesp_pkg::ACT_BACKSPACE, 8'h00);
      else if (b == aesp_pkg::BYTE_LF) emit(aesp_pkg::ACT_NEWLINE, 8'h00);
      else if (b == aesp_pkg::BYTE_TAB) emit(aesp_pkg::ACT_TAB, 8'h00);
      else if (b >= aesp_pkg::BYTE_PRINT_LO) emit(aesp_pkg::ACT_PRINT, b);
    endfunction

    function void apply_sgr();
      logic [31:0] v;
      v = bad_param ? 32'd0 : accum;
      if (v == aesp_pkg::SGR_RESET) begin
        next_fg   = aesp_pkg::FG_DEFAULT;
        next_bold = 1'b0;
      end else if (v == aesp_pkg::SGR_BOLD) begin
        next_bold = 1'b1;
      end else if (v >= aesp_pkg::SGR_FG_LO && v <= aesp_pkg::SGR_FG_HI) begin
        next_fg = 5'(v - aesp_pkg::SGR_FG_LO);
      end else if (v >= aesp_pkg::SGR_BFG_LO && v <= aesp_pkg::SGR_BFG_HI) begin
        next_fg = 5'(v - aesp_pkg::SGR_BFG_LO + 32'd8);
      end
      accum     = '0;
      bad_param = 1'b0;
    endfunction

    function void csi_param(logic [7:0] b);
      logic [31:0]    d;
      aesp_pkg::pat_t p;
      p = pat;
      d = {24'd0, b - aesp_pkg::BYTE_DIGIT_0};
      if (b == aesp_pkg::BYTE_SEMI) begin
        apply_sgr();
        pat = (p == aesp_pkg::PAT_ONE) ? aesp_pkg::PAT_ONE_SEMI : aesp_pkg::PAT_OTHER;
      end else if (b >= aesp_pkg::BYTE_DIGIT_0 && b <= aesp_pkg::BYTE_DIGIT_9) begin
        if (!bad_param) begin
          if (accum > (aesp_pkg::PARAM_MAX - d) / 32'd10) begin
            bad_param = 1'b1;
            accum     = '0;
          end else begin
            accum = accum * 32'd10 + d;
          end
        end
        if (p == aesp_pkg::PAT_EMPTY && b == aesp_pkg::BYTE_DIGIT_0) begin
          pat = aesp_pkg::PAT_ZERO;
        end else if (p == aesp_pkg::PAT_EMPTY && b == aesp_pkg::BYTE_DIGIT_2) begin
          pat = aesp_pkg::PAT_TWO;
        end else if (p == aesp_pkg::PAT_EMPTY && b == aesp_pkg::BYTE_DIGIT_1) begin
          pat = aesp_pkg::PAT_ONE;
        end else if (p == aesp_pkg::PAT_ONE_SEMI && b == aesp_pkg::BYTE_DIGIT_1) begin
          pat = aesp_pkg::PAT_ONE_SEMI_ONE;
        end else begin
          pat = aesp_pkg::PAT_OTHER;
        end
      end else begin
        bad_param = 1'b1;
        accum     = '0;
        pat       = aesp_pkg::PAT_OTHER;
      end
    endfunction

    function void csi_end(logic [7:0] b);
      aesp_pkg::pat_t p;
      p    = pat;
      mode = aesp_pkg::MODE_GROUND;
      if (b == aesp_pkg::BYTE_M) begin
        apply_sgr();
        cur_fg   = next_fg;
        cur_bold = next_bold;
      end else if (b == aesp_pkg::BYTE_K &&
                   (p == aesp_pkg::PAT_EMPTY || p == aesp_pkg::PAT_ZERO)) begin
        emit(aesp_pkg::ACT_ERASE_EOL, 8'h00);
      end else if (b == aesp_pkg::BYTE_K && p == aesp_pkg::PAT_TWO) begin
        emit(aesp_pkg::ACT_ERASE_LN, 8'h00);
      end else if (b == aesp_pkg::BYTE_H &&
                   (p == aesp_pkg::PAT_EMPTY || p == aesp_pkg::PAT_ONE_SEMI_ONE)) begin
        emit(aesp_pkg::ACT_HOME, 8'h00);
      end
    endfunction

    function void take_byte(logic [7:0] b);
      bytes_seen++;
      case (mode)
        aesp_pkg::MODE_ESC: begin
          if (b == aesp_pkg::BYTE_LBRACKET) begin
            mode      = aesp_pkg::MODE_CSI;
            accum     = '0;
            bad_param = 1'b0;
            pat       = aesp_pkg::PAT_EMPTY;
            next_fg   = cur_fg;
            next_bold = cur_bold;
          end else if (b == aesp_pkg::BYTE_RBRACKET) begin
            mode = aesp_pkg::MODE_OSC;
          end else if (b >= aesp_pkg::BYTE_FINAL_LO && b <= aesp_pkg::BYTE_ESC2_HI) begin
            mode = aesp_pkg::MODE_GROUND;
          end else begin
            mode = aesp_pkg::MODE_GROUND;
            ground_byte(b);
          end
        end
        aesp_pkg::MODE_CSI: begin
          if (b >= aesp_pkg::BYTE_FINAL_LO && b <= aesp_pkg::BYTE_FINAL_HI) csi_end(b);
          else csi_param(b);
        end
        aesp_pkg::MODE_OSC: begin
          if (b == aesp_pkg::BYTE_BEL) mode = aesp_pkg::MODE_GROUND;
          else if (b == aesp_pkg::BYTE_ESC) mode = aesp_pkg::MODE_OSC_ESC;
        end
        aesp_pkg::MODE_OSC_ESC: begin
          if (b == aesp_pkg::BYTE_BSLASH || b == aesp_pkg::BYTE_BEL) begin
            mode = aesp_pkg::MODE_GROUND;
          end else if (b != aesp_pkg::BYTE_ESC) begin
            mode = aesp_pkg::MODE_OSC;
          end
        end
        default: begin
          mode = aesp_pkg::MODE_GROUND;
          ground_byte(b);
        end
      endcase
    endfunction

    task match_cmd(logic [2:0] a, logic [7:0] ch, logic [4:0] fg, logic bd);
      aesp_pkg::cmd_t want;
      cmds_seen++;
      if (pending_cmds.size() == 0) begin
        report_mismatch("command with none pending, action", int'(a), -1);
      end else begin
        want = pending_cmds.pop_front();
        if (a !== want.action) report_mismatch("action", int'(a), int'(want.action));
        if (ch !== want.char_out) report_mismatch("char_out", int'(ch), int'(want.char_out));
        if (fg !== want.fg_color) report_mismatch("fg_color", int'(fg), int'(want.fg_color));
        if (bd !== want.bold) report_mismatch("bold", int'(bd), int'(want.bold));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_ready;
  logic [7:0] byte_in = 8'h00;
  logic       cmd_valid;
  logic       cmd_ready = 1'b0;
  logic [2:0] action;
  logic [7:0] char_out;
  logic [4:0] fg_color;
  logic       bold;

  term_cmd_model model = new();
  logic [7:0]    byte_q[$];
  int            burst_left = 0;
  int            idle_cycles = 0;
  int            ready_mode = 0;
  int            ready_left = 0;
  int            escapes_sent = 0;
  int            random_sent = 0;

  ansi_escape_stream_parser_top DUT (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_in    (byte_in),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .action     (action),
    .char_out   (char_out),
    .fg_color   (fg_color),
    .bold       (bold)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && byte_ready) model.take_byte(byte_in);
      if (cmd_valid && cmd_ready) model.match_cmd(action, char_out, fg_color, bold);
      if ((byte_valid && byte_ready) || (cmd_valid && cmd_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(8, 80);
    end
    ready_left--;
    case (ready_mode)
      0: cmd_ready <= 1'b1;
      1: cmd_ready <= 1'($urandom_range(0, 1));
      2: cmd_ready <= ($urandom_range(0, 3) == 0);
      default: cmd_ready <= ((ready_left % 16) > 11);
    endcase
  end

  function automatic void add_str(string s);
    foreach (s[i]) byte_q.push_back(s[i]);
  endfunction

  function automatic void add_esc(string s);
    byte_q.push_back(aesp_pkg::BYTE_ESC);
    add_str(s);
    escapes_sent++;
  endfunction

  function automatic string sgr_param();
    case ($urandom_range(0, 11))
      0: return "";
      1: return "0";
      2: return "1";
      3, 4: return $sformatf("%0d", 30 + $urandom_range(0, 7));
      5, 6: return $sformatf("%0d", 90 + $urandom_range(0, 7));
      7: return $sformatf("%0d", $urandom_range(0, 120));
      8: return "0033";
      9: begin
        case ($urandom_range(0, 3))
          0: return "2147483647";
          1: return "2147483648";
          2: return "4294967327";
          default: return $sformatf("%0d%0d", $urandom_range(1, 9999), $urandom);
        endcase
      end
      10: return $sformatf("%0d%c", 30 + $urandom_range(0, 7), 8'($urandom_range(33, 47)));
      default: return "?1";
    endcase
  endfunction

  function automatic logic [7:0] csi_filler();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b >= aesp_pkg::BYTE_FINAL_LO && b <= aesp_pkg::BYTE_FINAL_HI) b = b ^ 8'h80;
    return b;
  endfunction

  function automatic void gen_chunk();
    int         pick;
    int         n;
    logic [7:0] b;
    string      forms[11];
    forms = '{"", "0", "2", "1", "1;", "1;1", "1;1;", "2;", "01", "3", "12"};
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      repeat ($urandom_range(1, 4)) byte_q.push_back(8'($urandom_range(32, 255)));
    end else if (pick < 33) begin
      b = 8'($urandom_range(0, 31));
      byte_q.push_back((b == aesp_pkg::BYTE_ESC) ? aesp_pkg::BYTE_LF : b);
    end else if (pick < 53) begin
      add_esc("[");
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        if (i > 0) byte_q.push_back(aesp_pkg::BYTE_SEMI);
        add_str(sgr_param());
      end
      byte_q.push_back(aesp_pkg::BYTE_M);
    end else if (pick < 68) begin
      add_esc("[");
      add_str(forms[$urandom_range(0, 10)]);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: byte_q.push_back(aesp_pkg::BYTE_K);
        4, 5, 6, 7: byte_q.push_back(aesp_pkg::BYTE_H);
        default: byte_q.push_back(
          8'($urandom_range(aesp_pkg::BYTE_FINAL_LO, aesp_pkg::BYTE_FINAL_HI)));
      endcase
    end else if (pick < 76) begin
      add_esc("]");
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(0, 7) == 0) byte_q.push_back(aesp_pkg::BYTE_ESC);
        else byte_q.push_back(8'($urandom_range(32, 126)));
      end
      case ($urandom_range(0, 3))
        0: byte_q.push_back(aesp_pkg::BYTE_BEL);
        1: begin
          byte_q.push_back(aesp_pkg::BYTE_ESC);
          byte_q.push_back(aesp_pkg::BYTE_BSLASH);
        end
        2: begin
          byte_q.push_back(aesp_pkg::BYTE_ESC);
          byte_q.push_back(aesp_pkg::BYTE_BEL);
        end
        default: begin
          byte_q.push_back(aesp_pkg::BYTE_ESC);
          byte_q.push_back(aesp_pkg::BYTE_ESC);
          byte_q.push_back(aesp_pkg::BYTE_BSLASH);
        end
      endcase
    end else if (pick < 82) begin
      b = 8'($urandom_range(aesp_pkg::BYTE_FINAL_LO, aesp_pkg::BYTE_ESC2_HI));
      if (b == aesp_pkg::BYTE_LBRACKET || b == aesp_pkg::BYTE_RBRACKET) begin
        b = aesp_pkg::BYTE_FINAL_LO;
      end
      byte_q.push_back(aesp_pkg::BYTE_ESC);
      byte_q.push_back(b);
      escapes_sent++;
    end else if (pick < 88) begin
      b = 8'($urandom_range(0, 255));
      if (b >= aesp_pkg::BYTE_FINAL_LO && b <= aesp_pkg::BYTE_ESC2_HI) b = b ^ 8'h80;
      byte_q.push_back(aesp_pkg::BYTE_ESC);
      byte_q.push_back(b);
      escapes_sent++;
    end else if (pick < 94) begin
      add_esc("[");
      repeat ($urandom_range(0, 6)) byte_q.push_back(csi_filler());
      byte_q.push_back(8'($urandom_range(aesp_pkg::BYTE_FINAL_LO, aesp_pkg::BYTE_FINAL_HI)));
    end else begin
      repeat ($urandom_range(1, 3)) byte_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic drive_byte(logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 16);
    end
    burst_left--;
    byte_valid <= 1'b1;
    byte_in    <= b;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_queue();
    while (byte_q.size() > 0) drive_byte(byte_q.pop_front());
  endtask

  task automatic hold_until_drained();
    byte_valid <= 1'b0;
    @(negedge clk);
    while (model.pending_cmds.size() > 0) @(negedge clk);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    byte_q.push_back(8'h00);
    byte_q.push_back(8'hFF);
    byte_q.push_back(8'h7F);
    byte_q.push_back(aesp_pkg::BYTE_CR);
    byte_q.push_back(aesp_pkg::BYTE_BS);
    byte_q.push_back(aesp_pkg::BYTE_LF);
    byte_q.push_back(aesp_pkg::BYTE_TAB);
    add_esc("[1;91mA");
    add_esc("[K");
    add_esc("[2K");
    add_esc("[1;1H");
    add_esc("]t");
    byte_q.push_back(aesp_pkg::BYTE_BEL);
    add_esc("X");
    add_esc("q");
    add_esc("[mB");
    drain_queue();
    hold_until_drained();

    while (random_sent < RANDOM_BYTES) begin
      gen_chunk();
      random_sent += byte_q.size();
      drain_queue();
      if ($urandom_range(0, 59) == 0) hold_until_drained();
    end
    byte_valid <= 1'b0;

    while (model.pending_cmds.size() > 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Covered %0d input bytes with %0d escape sequences; %0d commands compared.",
             model.bytes_seen, escapes_sent, model.cmds_seen);
    $display("Mismatches found: %0d", model.mismatches);
    if (model.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
